// File: hw/rtl/rme_pkg.sv
// shared types, constants and helper functions for the euler angle block
`timescale 1ns / 1ps
package rme_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TAB_LEN = 24;
   localparam int ISQRT_STEPS = 16;
   localparam int SQ_W = 31;
   localparam int VEC_W = 34;
   localparam int Z_W = 27;
   localparam int ANG_W = 19;

   localparam logic signed [Z_W-1:0] QUARTER_TURN = 27'sd4194304;
   localparam logic [SQ_W-1:0] ONE_SQUARED = 31'd268435456;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [ANG_W-1:0] HALF_TURN = 19'sd32768;

   typedef struct packed {
      logic zero;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic lock;
      logic beta_pi;
      logic signed [16:0] m33;
      logic signed [16:0] ay;
      logic signed [16:0] ax;
      logic signed [16:0] gy;
      logic signed [16:0] gx;
   } side_type;

   typedef struct packed {
      logic lock;
      logic beta_pi;
      vec_type alpha;
      vec_type beta;
      vec_type gamma;
   } trio_type;

   // arctan(2^-i) with 2^24 per turn
   function automatic logic signed [Z_W-1:0] atan_fine(input logic [4:0] idx);
      logic signed [Z_W-1:0] r;
      begin
         case (idx)
            5'd0: r = 27'sd2097152;
            5'd1: r = 27'sd1238021;
            5'd2: r = 27'sd654136;
            5'd3: r = 27'sd332050;
            5'd4: r = 27'sd166669;
            5'd5: r = 27'sd83416;
            5'd6: r = 27'sd41718;
            5'd7: r = 27'sd20860;
            5'd8: r = 27'sd10430;
            5'd9: r = 27'sd5215;
            5'd10: r = 27'sd2608;
            5'd11: r = 27'sd1304;
            5'd12: r = 27'sd652;
            5'd13: r = 27'sd326;
            5'd14: r = 27'sd163;
            5'd15: r = 27'sd81;
            5'd16: r = 27'sd41;
            5'd17: r = 27'sd20;
            5'd18: r = 27'sd10;
            5'd19: r = 27'sd5;
            5'd20: r = 27'sd3;
            5'd21: r = 27'sd1;
            5'd22: r = 27'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // scale and turn a left half plane vector into the right half plane
   function automatic vec_type vec_init(input logic signed [16:0] y,
                                        input logic signed [16:0] x);
      vec_type v;
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      begin
         xs = VEC_W'(x) <<< 14;
         ys = VEC_W'(y) <<< 14;
         v.zero = (x == 17'sd0) && (y == 17'sd0);
         if (x < 17'sd0) begin
            if (y >= 17'sd0) begin
               v.z = QUARTER_TURN;
               v.x = ys;
               v.y = -xs;
            end else begin
               v.z = -QUARTER_TURN;
               v.x = -ys;
               v.y = xs;
            end
         end else begin
            v.z = '0;
            v.x = xs;
            v.y = ys;
         end
         return v;
      end
   endfunction

   // round the fine angle to 65536 per turn
   function automatic logic signed [ANG_W-1:0] round_angle(input vec_type v);
      logic signed [Z_W-1:0] t;
      begin
         t = (v.z + 27'sd128) >>> 8;
         return v.zero ? '0 : t[ANG_W-1:0];
      end
   endfunction

   function automatic logic signed [ANG_W-1:0] snap_angle(input logic signed [ANG_W-1:0] a,
                                                          input logic [7:0] thr);
      logic [ANG_W:0] mag;
      begin
         mag = a[ANG_W-1] ? -{a[ANG_W-1], a} : {a[ANG_W-1], a};
         return (mag < {12'd0, thr}) ? '0 : a;
      end
   endfunction

endpackage

// File: hw/rtl/rme_req_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface rme_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] m11;
   logic signed [15:0] m12;
   logic signed [15:0] m13;
   logic signed [15:0] m23;
   logic signed [15:0] m31;
   logic signed [15:0] m32;
   logic signed [15:0] m33;
   modport source (output valid, m11, m12, m13, m23, m31, m32, m33, input ready);
   modport sink (input valid, m11, m12, m13, m23, m31, m32, m33, output ready);
endinterface

interface rme_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] alpha_angle;
   logic [15:0] beta_angle;
   logic [15:0] gamma_angle;
   logic gimbal_lock;
   modport source (output valid, alpha_angle, beta_angle, gamma_angle, gimbal_lock,
                   input ready);
   modport sink (input valid, alpha_angle, beta_angle, gamma_angle, gimbal_lock,
                 output ready);
endinterface

// File: hw/rtl/rme_isqrt_stage.sv
// one restoring step of the integer square root, registered
`timescale 1ns / 1ps
module rme_isqrt_stage #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [rme_pkg::SQ_W-1:0] in_rem,
   input  logic [rme_pkg::SQ_W-1:0] in_root,
   input  rme_pkg::side_type in_side,
   output logic out_valid,
   output logic [rme_pkg::SQ_W-1:0] out_rem,
   output logic [rme_pkg::SQ_W-1:0] out_root,
   output rme_pkg::side_type out_side
);
   localparam int SH = rme_pkg::SQ_W - 1 - 2 * STEP;
   localparam logic [rme_pkg::SQ_W-1:0] BIT = rme_pkg::SQ_W'(1) << SH;

   logic valid_ff;
   logic [rme_pkg::SQ_W-1:0] rem_ff, rem_in, root_ff, root_in;
   rme_pkg::side_type side_ff;
   logic [rme_pkg::SQ_W:0] trial;

   always_comb begin
      trial = {1'b0, in_root} + {1'b0, BIT};
      if ({1'b0, in_rem} >= trial) begin
         rem_in = in_rem - trial[rme_pkg::SQ_W-1:0];
         root_in = (in_root >> 1) + BIT;
      end else begin
         rem_in = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem = rem_ff;
   assign out_root = root_ff;
   assign out_side = side_ff;
endmodule

// File: hw/rtl/rme_cordic_stage.sv
// one vectoring cordic iteration on all three angle paths, registered
`timescale 1ns / 1ps
module rme_cordic_stage #(
   parameter int IDX = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  rme_pkg::trio_type in_data,
   output logic out_valid,
   output rme_pkg::trio_type out_data
);
   localparam logic signed [rme_pkg::Z_W-1:0] ANG = rme_pkg::atan_fine(5'(IDX));

   logic valid_ff;
   rme_pkg::trio_type data_ff, data_in;

   function automatic rme_pkg::vec_type rotate(input rme_pkg::vec_type v);
      rme_pkg::vec_type r;
      logic signed [rme_pkg::VEC_W-1:0] dx, dy;
      begin
         dx = v.y >>> IDX;
         dy = v.x >>> IDX;
         r.zero = v.zero;
         if (!v.y[rme_pkg::VEC_W-1]) begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ANG;
         end else begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ANG;
         end
         return r;
      end
   endfunction

   always_comb begin
      data_in.lock = in_data.lock;
      data_in.beta_pi = in_data.beta_pi;
      data_in.alpha = rotate(in_data.alpha);
      data_in.beta = rotate(in_data.beta);
      data_in.gamma = rotate(in_data.gamma);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

// File: hw/rtl/rotation_matrix_to_euler_angles.sv
// top level: rotation matrix to bunge zxz euler angles
// Accepts one matrix word per cycle while the pipeline advances and returns one angle
// word per matrix, in order. Registers in order: the m33 square, sixteen integer
// square root steps, the quarter-turn pre-rotation, the cordic iterations (alpha,
// beta and gamma run side by side) and the output register with rounding and
// snapping. The whole pipeline advances together; it holds while a finished word
// waits on the response side and takes a new word whenever the output register is
// empty or being drained.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_angles #(
   parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   rme_req_if.sink req_chan,
   rme_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   localparam int NS = rme_pkg::ISQRT_STEPS;

   logic adv;
   logic [7:0] snap_thr_ff;

   // input stage
   logic in_valid_ff;
   logic [rme_pkg::SQ_W-1:0] in_rem_ff, in_rem_in;
   rme_pkg::side_type in_side_ff, in_side_in;
   logic signed [31:0] sq;

   logic isq_v [0:NS];
   logic [rme_pkg::SQ_W-1:0] isq_rem [0:NS];
   logic [rme_pkg::SQ_W-1:0] isq_root [0:NS];
   rme_pkg::side_type isq_side [0:NS];

   logic cs_v [0:CORDIC_STAGES];
   rme_pkg::trio_type cs_d [0:CORDIC_STAGES];
   logic pre_valid_ff;
   rme_pkg::trio_type pre_ff, pre_in;

   logic out_valid_ff;
   logic [15:0] alpha_ff, alpha_in, beta_ff, beta_in, gamma_ff, gamma_in;
   logic lock_ff;
   logic signed [rme_pkg::ANG_W-1:0] ra, rb, rg, sa, sb, sg;

   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_thr_ff <= 8'd1;
      end else if (csr_wr_en) begin
         snap_thr_ff <= csr_wr_data;
      end
   end

   always_comb begin
      sq = 32'(req_chan.m33) * 32'(req_chan.m33);
      in_rem_in = rme_pkg::ONE_SQUARED - sq[rme_pkg::SQ_W-1:0];
      in_side_in.lock = (req_chan.m33 >= rme_pkg::ONE_Q14) || (req_chan.m33 <= -rme_pkg::ONE_Q14);
      in_side_in.beta_pi = req_chan.m33[15];
      in_side_in.m33 = 17'(req_chan.m33);
      in_side_in.ay = in_side_in.lock ? 17'(req_chan.m12) : 17'(req_chan.m31);
      in_side_in.ax = in_side_in.lock ? 17'(req_chan.m11) : -17'(req_chan.m32);
      in_side_in.gy = 17'(req_chan.m13);
      in_side_in.gx = 17'(req_chan.m23);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_rem_ff <= in_rem_in;
         in_side_ff <= in_side_in;
      end
   end

   assign isq_v[0] = in_valid_ff;
   assign isq_rem[0] = in_rem_ff;
   assign isq_root[0] = '0;
   assign isq_side[0] = in_side_ff;

   for (genvar k = 0; k < NS; k++) begin : g_isqrt
      rme_isqrt_stage #(.STEP(k)) u_step (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(isq_v[k]), .in_rem(isq_rem[k]), .in_root(isq_root[k]),
         .in_side(isq_side[k]),
         .out_valid(isq_v[k+1]), .out_rem(isq_rem[k+1]), .out_root(isq_root[k+1]),
         .out_side(isq_side[k+1])
      );
   end

   // quarter turn pre-rotation
   always_comb begin
      pre_in.lock = isq_side[NS].lock;
      pre_in.beta_pi = isq_side[NS].beta_pi;
      pre_in.alpha = rme_pkg::vec_init(isq_side[NS].ay, isq_side[NS].ax);
      pre_in.beta = rme_pkg::vec_init({1'b0, isq_root[NS][15:0]}, isq_side[NS].m33);
      pre_in.gamma = rme_pkg::vec_init(isq_side[NS].gy, isq_side[NS].gx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= isq_v[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff <= pre_in;
      end
   end

   assign cs_v[0] = pre_valid_ff;
   assign cs_d[0] = pre_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rme_cordic_stage #(.IDX(i)) u_iter (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(cs_v[i]), .in_data(cs_d[i]),
         .out_valid(cs_v[i+1]), .out_data(cs_d[i+1])
      );
   end

   // round, pick degenerate values, snap and clamp
   always_comb begin
      ra = rme_pkg::round_angle(cs_d[CORDIC_STAGES].alpha);
      rb = cs_d[CORDIC_STAGES].lock ?
           (cs_d[CORDIC_STAGES].beta_pi ? rme_pkg::HALF_TURN : '0) :
           rme_pkg::round_angle(cs_d[CORDIC_STAGES].beta);
      rg = cs_d[CORDIC_STAGES].lock ? '0 : rme_pkg::round_angle(cs_d[CORDIC_STAGES].gamma);
      sa = rme_pkg::snap_angle(ra, snap_thr_ff);
      sb = rme_pkg::snap_angle(rb, snap_thr_ff);
      sg = rme_pkg::snap_angle(rg, snap_thr_ff);
      if (sb < 0) begin
         beta_in = '0;
      end else if (sb > rme_pkg::HALF_TURN) begin
         beta_in = rme_pkg::HALF_TURN[15:0];
      end else begin
         beta_in = sb[15:0];
      end
      alpha_in = sa[15:0];
      gamma_in = sg[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cs_v[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff <= alpha_in;
         beta_ff <= beta_in;
         gamma_ff <= gamma_in;
         lock_ff <= cs_d[CORDIC_STAGES].lock;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.alpha_angle = alpha_ff;
   assign rsp_chan.beta_angle = beta_ff;
   assign rsp_chan.gamma_angle = gamma_ff;
   assign rsp_chan.gimbal_lock = lock_ff;

   a_lock_gamma: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && lock_ff |-> gamma_ff == 16'd0)
      else $error("gamma not zero under gimbal lock");

   a_beta_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> beta_ff <= 16'd32768)
      else $error("beta beyond half turn");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("word taken while output stalled");

   a_lock_beta: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && lock_ff |-> beta_ff == 16'd0 || beta_ff == 16'd32768)
      else $error("beta not at a pole under gimbal lock");
endmodule

// File: tb/tb_rotation_matrix_to_euler_angles.sv
// self-checking testbench for the rotation matrix to euler angles block
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler_angles;

   localparam int STAGES = rme_pkg::CORDIC_STAGES_DEF;
   localparam int LATENCY = STAGES + 19;
   localparam int N_RANDOM = 1475;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic signed [15:0] m11, m12, m13, m23, m31, m32, m33;
   } matrix_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] beta;
      logic [15:0] gamma;
      logic lock;
   } angles_type;

   typedef struct {
      matrix_type m;
      logic known;
      angles_type a;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [7:0] csr_wr_data = 0;

   rme_req_if req_chan();
   rme_rsp_if rsp_chan();

   rotation_matrix_to_euler_angles uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic [7:0] snap_thr;
   angles_type pending_angles[$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_locked = 0;
   int idle_cycles = 0;
   logic hold_off = 0;
   logic big_stall = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.m11 = 0; req_chan.m12 = 0; req_chan.m13 = 0; req_chan.m23 = 0;
      req_chan.m31 = 0; req_chan.m32 = 0; req_chan.m33 = 0;
      rsp_chan.ready = 0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_tab(int i);
      longint tab[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                          20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
                          41, 20, 10, 5, 3, 1, 1, 0};
      return tab[i];
   endfunction

   function automatic longint atan2_bam(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 16384;
      y = y * 16384;
      if (x < 0) begin
         if (y >= 0) begin
            z = 4194304; t = x; x = y; y = -t;
         end else begin
            z = -4194304; t = x; x = -y; y = t;
         end
      end
      for (int i = 0; i < STAGES && i < rme_pkg::TAB_LEN; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_tab(i);
         end else begin
            x -= dx; y += dy; z -= atan_tab(i);
         end
      end
      return floor_shift(z + 128, 8);
   endfunction

   function automatic longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint snapped(longint a);
      longint m;
      m = a < 0 ? -a : a;
      return m < snap_thr ? 0 : a;
   endfunction

   function automatic angles_type euler_of(matrix_type m);
      angles_type r;
      longint al, be, ga, s;
      if (m.m33 >= 16384 || m.m33 <= -16384) begin
         r.lock = 1;
         al = atan2_bam(m.m12, m.m11);
         be = (m.m33 >= 16384) ? 0 : 32768;
         ga = 0;
      end else begin
         r.lock = 0;
         s = root_floor(64'd268435456 - longint'(m.m33) * longint'(m.m33));
         al = atan2_bam(m.m31, -longint'(m.m32));
         be = atan2_bam(s, m.m33);
         ga = atan2_bam(m.m13, m.m23);
      end
      al = snapped(al);
      be = snapped(be);
      ga = snapped(ga);
      if (be < 0) be = 0;
      if (be > 32768) be = 32768;
      r.alpha = al[15:0];
      r.beta = be[15:0];
      r.gamma = ga[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch %s at result %0d: got %0d expected %0d", what, n_checked, got,
               want);
   endtask

   // receiver: random stall pattern, plus a long hold-off when asked
   logic [3:0] stall_pat = 4'b1011;
   always @(posedge clock) begin
      if (!reset) begin
         stall_pat <= {stall_pat[2:0], stall_pat[3] ^ ($urandom_range(0, 3) == 0)};
         if (big_stall) rsp_chan.ready <= 0;
         else if (hold_off) rsp_chan.ready <= 1;
         else rsp_chan.ready <= stall_pat[0] | ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_angles.size() == 0) begin
            errors++;
            $display("unexpected result word");
         end else begin
            e = pending_angles.pop_front();
            if (rsp_chan.alpha_angle !== e.alpha)
               report_mismatch("alpha", rsp_chan.alpha_angle, e.alpha);
            if (rsp_chan.beta_angle !== e.beta)
               report_mismatch("beta", rsp_chan.beta_angle, e.beta);
            if (rsp_chan.gamma_angle !== e.gamma)
               report_mismatch("gamma", rsp_chan.gamma_angle, e.gamma);
            if (rsp_chan.gimbal_lock !== e.lock)
               report_mismatch("lock", 16'(rsp_chan.gimbal_lock), 16'(e.lock));
            if (e.lock) n_locked++;
         end
         n_checked++;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!big_stall)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** rotation_matrix_to_euler_angles: FAILED **");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_word(matrix_type m, int gap);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      {req_chan.m11, req_chan.m12, req_chan.m13, req_chan.m23, req_chan.m31,
       req_chan.m32, req_chan.m33} <= m;
      pending_angles.push_back(euler_of(m));
      do @(posedge clock); while (!req_chan.ready);
      n_sent++;
   endtask

   task automatic finish_stream();
      req_chan.valid <= 0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_snap(logic [7:0] v);
      finish_stream();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      snap_thr = v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic signed [15:0] rnd_entry();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'(signed'($urandom_range(0, 65535)));
         3: return 16'sd0;
         default: return 16'(signed'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic matrix_type rnd_matrix();
      matrix_type m;
      m.m11 = rnd_entry(); m.m12 = rnd_entry(); m.m13 = rnd_entry();
      m.m23 = rnd_entry(); m.m31 = rnd_entry(); m.m32 = rnd_entry();
      case ($urandom_range(0, 7))
         0: m.m33 = 16'sd16384;
         1: m.m33 = -16'sd16384;
         2: m.m33 = 16'(signed'($urandom_range(0, 65535)));
         3: m.m33 = 16'(signed'($urandom_range(0, 8)) + 16375);
         default: m.m33 = 16'(signed'($urandom_range(0, 32766)) - 16383);
      endcase
      return m;
   endfunction

   row_type rows[$];
   int gap;
   int burst;

   initial begin
      matrix_type z;
      row_type r;
      snap_thr = 1;
      z = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table: zero, extremes, lock both signs, out of range, wrap cases
      r.known = 1; r.m = '0; r.a = '{16'd0, 16'd16384, 16'd0, 1'b0};
      rows.push_back(r);
      r.m = z; r.m.m33 = 16'sd16384; r.a = '{16'd0, 16'd0, 16'd0, 1'b1};
      rows.push_back(r);
      r.m = z; r.m.m33 = -16'sd16384; r.a = '{16'd0, 16'd32768, 16'd0, 1'b1};
      rows.push_back(r);
      r.m = z; r.m.m33 = 16'h8000; r.a = '{16'd0, 16'd32768, 16'd0, 1'b1};
      rows.push_back(r);
      r.m = z; r.m.m33 = 16'h7fff; r.a = '{16'd0, 16'd0, 16'd0, 1'b1};
      rows.push_back(r);
      r.known = 0;
      r.m = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
      rows.push_back(r);
      r.m = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384};
      rows.push_back(r);
      r.m = '{-16'sd16384, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
      rows.push_back(r);
      r.m = '{16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.m = '{16'sd0, 16'sd0, -16'sd16384, -16'sd1, 16'sd1, 16'sd16384, 16'sd16383};
      rows.push_back(r);
      r.m = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, -16'sd16383};
      rows.push_back(r);
      r.m = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'sd1};
      rows.push_back(r);
      r.m = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
      rows.push_back(r);
      r.m = '{16'sd11585, 16'sd11585, 16'sd8192, -16'sd8192, 16'sd100, -16'sd3, 16'sd0};
      rows.push_back(r);

      foreach (rows[i]) begin
         send_word(rows[i].m, 0);
         if (rows[i].known && pending_angles[$] != rows[i].a) begin
            errors++;
            $display("predictor disagrees with table row %0d", i);
         end
      end

      // long receiver hold-off while words keep coming
      finish_stream();
      big_stall = 1;
      fork
         begin
            repeat (LATENCY * 3) @(posedge clock);
            big_stall = 0;
         end
         for (int i = 0; i < 60; i++) send_word(rnd_matrix(), 0);
      join

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_snap(8'd0);
            1: set_snap(8'd255);
            2: set_snap(8'(($urandom_range(2, 254))));
            3: set_snap(8'd1);
            default: set_snap(8'(($urandom_range(0, 255))));
         endcase
         hold_off = (phase == 3);
         for (int i = 0; i < N_RANDOM / 5; i += burst) begin
            burst = $urandom_range(1, 40);
            if (burst > N_RANDOM / 5 - i) burst = N_RANDOM / 5 - i;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            for (int k = 0; k < burst; k++) send_word(rnd_matrix(), k == 0 ? gap : 0);
         end
      end
      finish_stream();

      $display("sent %0d matrices, checked %0d angle words, %0d in gimbal lock",
               n_sent, n_checked, n_locked);
      $display("snap thresholds 0, 1, 255 and random ones, with input and output stalls");
      if (errors == 0 && pending_angles.size() == 0)
         $display("** rotation_matrix_to_euler_angles: PASSED **");
      else
         $display("** rotation_matrix_to_euler_angles: FAILED **");
      $finish;
   end
endmodule

// File: rotation_matrix_to_euler_angles.f
hw/rtl/rme_pkg.sv
hw/rtl/rme_req_if.sv
hw/rtl/rme_isqrt_stage.sv
hw/rtl/rme_cordic_stage.sv
hw/rtl/rotation_matrix_to_euler_angles.sv
tb/tb_rotation_matrix_to_euler_angles.sv
